### src/tpfg_pkg.sv
package tpfg_pkg;

    localparam int PHASE_BITS   = 16;
    localparam int TABLE_BITS   = 10;
    localparam int QUARTER_BITS = TABLE_BITS - 2;
    localparam int QUARTER      = 1 << QUARTER_BITS;
    localparam int STEP_BITS    = 16;
    localparam int POS_BITS     = 11;
    localparam int FRAME_BITS   = 2;
    localparam int PIX_BITS     = 8;
    localparam int DATA_BITS    = 24;

    localparam logic [PHASE_BITS-1:0] OFF_ONE = PHASE_BITS'(((1 << PHASE_BITS) + 1) / 3);
    localparam logic [PHASE_BITS-1:0] OFF_TWO = PHASE_BITS'(((2 << PHASE_BITS) + 1) / 3);

    localparam logic [PIX_BITS:0] MID_LEVEL = (PIX_BITS + 1)'(1 << (PIX_BITS - 1));
    localparam logic [PIX_BITS:0] TOP_LEVEL = (PIX_BITS + 1)'((1 << PIX_BITS) - 1);

    localparam real TWO_PI = 6.283185307179586;

    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [TABLE_BITS-1:0] tbl_idx_t;
    typedef logic [PIX_BITS-1:0]   pix_t;
    typedef pix_t cos_tbl_t [QUARTER];

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_PHASE_STEP  = 1'b0,
        REG_ORIENTATION = 1'b1
    } cfg_reg_t;

    // phase offset selectors
    typedef enum logic [1:0] {
        OFF_SEL_ZERO = 2'd0,
        OFF_SEL_ONE  = 2'd1,
        OFF_SEL_TWO  = 2'd2
    } off_sel_t;

    // floor(128 * cos(2*pi*a / 2^TABLE_BITS)) over the first quadrant
    function automatic cos_tbl_t build_cos_table();
        cos_tbl_t tbl;
        real      ang;
        integer   v;
        integer   a;
        for (a = 0; a < QUARTER; a++) begin
            ang    = TWO_PI * a / (1 << TABLE_BITS);
            v      = $rtoi($floor(128.0 * $cos(ang)));
            tbl[a] = v[PIX_BITS-1:0];
        end
        return tbl;
    endfunction

    localparam cos_tbl_t COS_TABLE = build_cos_table();

    function automatic phase_t offset_of(off_sel_t sel);
        phase_t off;
        case (sel)
            OFF_SEL_ZERO: off = '0;
            OFF_SEL_ONE:  off = OFF_ONE;
            OFF_SEL_TWO:  off = OFF_TWO;
            default:      off = '0;
        endcase
        return off;
    endfunction

endpackage

### src/tpfg_cos_rom.sv
module tpfg_cos_rom (
    input  tpfg_pkg::tbl_idx_t idx,
    output tpfg_pkg::pix_t     level
);
    import tpfg_pkg::*;

    logic [1:0]              quad;
    logic [QUARTER_BITS-1:0] r;
    logic [QUARTER_BITS:0]   a;
    logic                    use_sin;
    logic                    negative;
    logic                    at_zero;
    logic                    exact;
    logic [PIX_BITS:0]       f;
    logic [PIX_BITS:0]       pos_v;
    logic [PIX_BITS:0]       neg_c;

    assign quad     = idx[TABLE_BITS-1 -: 2];
    assign r        = idx[QUARTER_BITS-1:0];
    assign use_sin  = quad[0];
    assign negative = quad[0] ^ quad[1];

    // sine of r is cosine of quarter minus r
    assign a       = use_sin ? ((QUARTER_BITS + 1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
    assign at_zero = a[QUARTER_BITS];
    // angle zero gives full scale; a quarter turn lies past the table and gives zero
    assign f       = at_zero ? '0 :
                     (a == '0) ? MID_LEVEL : {1'b0, COS_TABLE[a[QUARTER_BITS-1:0]]};
    assign exact   = at_zero || (a == '0);

    assign pos_v = MID_LEVEL + f;
    assign neg_c = f + (PIX_BITS + 1)'(!exact);

    always_comb begin
        if (!negative) begin
            level = (pos_v > TOP_LEVEL) ? TOP_LEVEL[PIX_BITS-1:0] : pos_v[PIX_BITS-1:0];
        end else begin
            level = (neg_c >= MID_LEVEL) ? '0 : PIX_BITS'(MID_LEVEL - neg_c);
        end
    end

endmodule

### src/tpfg_phase_gen.sv
module tpfg_phase_gen (
    input  logic [tpfg_pkg::FRAME_BITS-1:0] frame,
    input  logic [tpfg_pkg::POS_BITS-1:0]   pos,
    input  logic [tpfg_pkg::STEP_BITS-1:0]  phase_step,
    output tpfg_pkg::tbl_idx_t              red_idx,
    output tpfg_pkg::tbl_idx_t              green_idx,
    output tpfg_pkg::tbl_idx_t              blue_idx
);
    import tpfg_pkg::*;

    logic [POS_BITS+STEP_BITS-1:0] prod;
    phase_t                        base;
    off_sel_t                      sel_red;
    off_sel_t                      sel_green;
    off_sel_t                      sel_blue;
    phase_t                        ph_red;
    phase_t                        ph_green;
    phase_t                        ph_blue;

    assign prod = {{STEP_BITS{1'b0}}, pos} * {{POS_BITS{1'b0}}, phase_step};
    assign base = prod[PHASE_BITS-1:0];

    // channel c of frame k takes offset (k - c) mod 3, frame three counts as frame zero
    always_comb begin
        case (frame)
            2'd1: begin
                sel_red   = OFF_SEL_ONE;
                sel_green = OFF_SEL_ZERO;
                sel_blue  = OFF_SEL_TWO;
            end
            2'd2: begin
                sel_red   = OFF_SEL_TWO;
                sel_green = OFF_SEL_ONE;
                sel_blue  = OFF_SEL_ZERO;
            end
            default: begin
                sel_red   = OFF_SEL_ZERO;
                sel_green = OFF_SEL_TWO;
                sel_blue  = OFF_SEL_ONE;
            end
        endcase
    end

    assign ph_red   = base + offset_of(sel_red);
    assign ph_green = base + offset_of(sel_green);
    assign ph_blue  = base + offset_of(sel_blue);

    assign red_idx   = ph_red[PHASE_BITS-1 -: TABLE_BITS];
    assign green_idx = ph_green[PHASE_BITS-1 -: TABLE_BITS];
    assign blue_idx  = ph_blue[PHASE_BITS-1 -: TABLE_BITS];

endmodule

### src/three_phase_fringe_pattern_gen.sv
// Three-phase fringe pattern generator.
// Input stream s_*: one request per pixel, s_tdata carries frame, column and row.
// Output stream m_*: one result per request, s_tdata order kept, m_tdata
// carries the red, green and blue intensities of that pixel.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr
// (0 phase step, 1 orientation); write only while no request is in flight.
// Pipeline: an accepted request is registered in the input register; its
// result is loaded into the output register, driving m_tvalid, once it is free.
// Throughput: one pixel per clock while m_tready is high; the path between
// the two registers is the position by step multiply, the phase offset add
// and the cosine table.
// Stall: while m_tready is low the output holds and one more request fills
// the input register, after which s_tready drops until the output drains.
// Reset: aresetn low empties both registers and clears phase step and
// orientation to zero.
module three_phase_fringe_pattern_gen (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [0:0]                     cfg_addr,
    input  logic [tpfg_pkg::STEP_BITS-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tpfg_pkg::DATA_BITS-1:0] s_tdata,  // frame[1:0], column[12:2], row[23:13]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tpfg_pkg::DATA_BITS-1:0] m_tdata   // red[7:0], green[15:8], blue[23:16]
);
    import tpfg_pkg::*;

    logic [STEP_BITS-1:0]  phase_step_reg;
    logic                  orientation_reg;
    logic                  s1_valid_reg;
    logic [FRAME_BITS-1:0] s1_frame_reg;
    logic [POS_BITS-1:0]   s1_pos_reg;
    logic                  out_valid_reg;
    pix_t                  red_reg;
    pix_t                  green_reg;
    pix_t                  blue_reg;

    logic [FRAME_BITS-1:0] in_frame;
    logic [POS_BITS-1:0]   in_column;
    logic [POS_BITS-1:0]   in_row;
    logic [POS_BITS-1:0]   pos_next;
    logic                  out_en;
    logic                  in_en;
    tbl_idx_t              red_idx;
    tbl_idx_t              green_idx;
    tbl_idx_t              blue_idx;
    pix_t                  red_next;
    pix_t                  green_next;
    pix_t                  blue_next;

    assign in_frame  = s_tdata[FRAME_BITS-1:0];
    assign in_column = s_tdata[FRAME_BITS +: POS_BITS];
    assign in_row    = s_tdata[FRAME_BITS+POS_BITS +: POS_BITS];
    assign pos_next  = orientation_reg ? in_row : in_column;

    assign out_en   = !out_valid_reg || m_tready;
    assign in_en    = !s1_valid_reg || out_en;
    assign s_tready = in_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg  <= '0;
            orientation_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_PHASE_STEP:  phase_step_reg  <= cfg_wdata;
                REG_ORIENTATION: orientation_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_en) begin
                s1_valid_reg <= s_tvalid;
            end
            if (out_en) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en) begin
            s1_frame_reg <= in_frame;
            s1_pos_reg   <= pos_next;
        end
        if (out_en) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    tpfg_phase_gen u_phase (
        .frame      (s1_frame_reg),
        .pos        (s1_pos_reg),
        .phase_step (phase_step_reg),
        .red_idx    (red_idx),
        .green_idx  (green_idx),
        .blue_idx   (blue_idx)
    );

    tpfg_cos_rom u_rom_red (
        .idx   (red_idx),
        .level (red_next)
    );

    tpfg_cos_rom u_rom_green (
        .idx   (green_idx),
        .level (green_next)
    );

    tpfg_cos_rom u_rom_blue (
        .idx   (blue_idx),
        .level (blue_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};

`ifndef SYNTHESIS
    // a full input stage behind a stalled output must not take another request
    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("request taken while both stages are full and stalled");

    // an accepted request lands in the input stage
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> s1_valid_reg)
        else $error("accepted request lost at the input stage");

    // a pending input item moves to the output when the output is free
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_en) |=> m_tvalid)
        else $error("pending item did not reach the output register");

    // an output that was not taken stays valid
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed while stalled");
`endif

endmodule
